@@ design/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam logic [15:0] LEN_OVERHEAD = 16'd3;

    localparam logic [7:0] HDR_FIRST_RESET  = 8'hEF;
    localparam logic [7:0] HDR_SECOND_RESET = 8'h01;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_position;
        logic [7:0] frame_packet_id;
        logic [7:0] frame_command;
        logic [8:0] frame_payload_length;
        logic       checksum_good;
        logic       frame_last;
    } sfp_result_t;

endpackage

@@ design/sfp_parser.sv @@
// ----------------------------------------------------------------------------
// sfp_parser
// Per-byte frame state machine: header hunt, length check, running sum,
// payload and frame-end results.
// ----------------------------------------------------------------------------
module sfp_parser
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  hdr_first,
    input  logic [7:0]  hdr_second,
    output logic        res_valid,
    output sfp_result_t res
);

    localparam int CNT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD + 1) : 1;
    localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD + 3);

    typedef enum logic [3:0] {
        PH_HDR1, PH_HDR2, PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3,
        PH_PID, PH_LENH, PH_LENL, PH_CMD, PH_PAYLOAD, PH_SUMH, PH_SUML
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [15:0]      len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       sumh_reg, sumh_next;
    logic [7:0]       pid_reg, pid_next;
    logic [7:0]       cmd_reg, cmd_next;

    logic [15:0]      len_low;
    logic [15:0]      plen;
    logic [CNT_W:0]   cnt_plus;
    logic [15:0]      sum_add;

    assign len_low  = {len_reg[15:8], in_byte};
    assign plen     = len_reg - LEN_OVERHEAD;
    assign cnt_plus = {1'b0, cnt_reg} + 1'b1;
    assign sum_add  = sum_reg + {8'h00, in_byte};

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        sumh_next  = sumh_reg;
        pid_next   = pid_reg;
        cmd_next   = cmd_reg;
        res_valid  = 1'b0;
        res.result_kind          = KIND_PAYLOAD;
        res.data_byte            = 8'h00;
        res.byte_position        = 8'h00;
        res.frame_packet_id      = pid_reg;
        res.frame_command        = cmd_reg;
        res.frame_payload_length = plen[8:0];
        res.checksum_good        = 1'b0;
        res.frame_last           = 1'b0;
        unique case (phase_reg)
            PH_HDR1: begin
                if (in_byte == hdr_first) begin
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2: begin
                phase_next = (in_byte == hdr_second) ? PH_ADDR0 : PH_HDR1;
            end
            PH_ADDR0: phase_next = PH_ADDR1;
            PH_ADDR1: phase_next = PH_ADDR2;
            PH_ADDR2: phase_next = PH_ADDR3;
            PH_ADDR3: phase_next = PH_PID;
            PH_PID: begin
                pid_next   = in_byte;
                sum_next   = {8'h00, in_byte};
                phase_next = PH_LENH;
            end
            PH_LENH: begin
                len_next   = {in_byte, 8'h00};
                sum_next   = sum_add;
                phase_next = PH_LENL;
            end
            PH_LENL: begin
                len_next = len_low;
                sum_next = sum_add;
                if (len_low < LEN_OVERHEAD || {1'b0, len_low} > LEN_MAX) begin
                    phase_next = PH_HDR1;
                end else begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_next = in_byte;
                sum_next = sum_add;
                if (len_reg == LEN_OVERHEAD) begin
                    phase_next = PH_SUMH;
                end else begin
                    cnt_next   = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_next          = sum_add;
                res_valid         = 1'b1;
                res.data_byte     = in_byte;
                res.byte_position = 8'(cnt_reg);
                cnt_next          = cnt_plus[CNT_W-1:0];
                if (17'(cnt_plus) >= {1'b0, plen}) begin
                    phase_next = PH_SUMH;
                end
            end
            PH_SUMH: begin
                sumh_next  = in_byte;
                phase_next = PH_SUML;
            end
            PH_SUML: begin
                res_valid         = 1'b1;
                res.result_kind   = KIND_FRAME_END;
                res.checksum_good = ({sumh_reg, in_byte} == sum_reg);
                res.frame_last    = 1'b1;
                phase_next        = PH_HDR1;
            end
            default: phase_next = PH_HDR1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sumh_reg  <= '0;
            pid_reg   <= '0;
            cmd_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            sumh_reg  <= sumh_next;
            pid_reg   <= pid_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule

@@ design/serial_frame_parser_sum16.sv @@
// Output: each result is registered in the output entry, or in the skid entry while the output entry is held.
// Throughput: one byte per cycle while s_tready is high; the parser state updates in a single pass.
// A two-entry output (register plus skid) keeps s_tready high while one
// result waits; s_tready falls only when both entries are full.
// Reset: synchronous, active low; returns to header hunt, headers to 0xEF, 0x01.
// ----------------------------------------------------------------------------
// serial_frame_parser_sum16
// Byte-stream frame parser with 16-bit additive checksum verdict.
// ----------------------------------------------------------------------------
module serial_frame_parser_sum16
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // in_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // data_byte, byte_position, frame_packet_id, frame_command,
    // frame_payload_length, checksum_good, zero pad
    output logic [47:0]          m_tdata,
    output logic [0:0]           m_tuser,   // result_kind
    output logic                 m_tlast    // frame_last
);

    logic [7:0]  hdr_first_reg;
    logic [7:0]  hdr_second_reg;

    logic        step;
    logic        res_valid;
    sfp_result_t res;

    logic        out_valid_reg;
    sfp_result_t out_reg;
    logic        skid_valid_reg;
    sfp_result_t skid_reg;
    logic        pop;
    logic        push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_first_reg  <= HDR_FIRST_RESET;
            hdr_second_reg <= HDR_SECOND_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_HDR_FIRST) begin
                hdr_first_reg <= cfg_wr_data;
            end
            if (cfg_wr_index == CFG_HDR_SECOND) begin
                hdr_second_reg <= cfg_wr_data;
            end
        end
    end

    assign s_tready = !skid_valid_reg;
    assign step     = s_tvalid && s_tready;
    assign push     = step && res_valid;
    assign pop      = out_valid_reg && m_tready;

    sfp_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (s_tdata),
        .hdr_first (hdr_first_reg),
        .hdr_second(hdr_second_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
                if (push) begin
                    out_reg <= res;
                end
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= push;
            if (push) begin
                out_reg <= res;
            end
        end else if (push) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_reg.checksum_good, out_reg.frame_payload_length,
                       out_reg.frame_command, out_reg.frame_packet_id,
                       out_reg.byte_position, out_reg.data_byte};
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.frame_last;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_last_is_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser[0]))
        else $error("frame_last and result_kind disagree");

    a_end_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[15:0] == 16'h0000))
        else $error("frame end carries payload data");
`endif

endmodule
